// ===== hw/rtl/rsp_pkg.sv =====
`default_nettype none
package rsp_pkg;
   localparam int Capacity = 1024;
   localparam int NodeW = 10;
   localparam int CountW = 11;
   localparam int Slices = 10;
   localparam int RandomSlices = 8;
   localparam int SliceW = 4;
   localparam int ValueW = 64;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_PICK = 2'd1;
   localparam logic [1:0] CMD_PUT = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PICK_SCAN,
      S_PICK_READ,
      S_PICK_DONE,
      S_PUT_LINK,
      S_BUBBLE,
      S_RESP
   } state_type;
endpackage
`default_nettype wire

// ===== hw/rtl/rsp_ram.sv =====
`default_nettype none
module rsp_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(Depth)-1:0]  wr_addr,
   input  wire [Width-1:0]          wr_data,
   input  wire [$clog2(Depth)-1:0]  rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/randomized_slice_pool_unit.sv =====
// A full store or an empty pool goes straight to the response state. A pick scans
// up to eight slices, one per cycle; an add, a put or a pick then bubbles the slice
// order, one swap per cycle. Throughput: one transaction at a time; a request is
// taken only when idle with the response register empty. Node store is one RAM
// (value+link), one write, one read.
// Reset: synchronous active high; pool empty, identity slice order, ring mode on.
`default_nettype none
module randomized_slice_pool_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // [1:0] command, [65:2] item_value, [68:66] random_slice, zero fill
   input  wire  [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // [63:0] picked_value, [65:64] status, zero fill
   output logic [71:0]  rsp_tdata,
   input  wire          csr_wr_en,
   input  wire          csr_wr_data
);
   localparam int NW = rsp_pkg::NodeW;
   localparam int CW = rsp_pkg::CountW;
   localparam int SW = rsp_pkg::SliceW;
   localparam int VW = rsp_pkg::ValueW;
   localparam int NS = rsp_pkg::Slices;

   rsp_pkg::state_type state_ff, state_in;

   logic ring_ff;
   logic pick_sel_ff, pick_sel_in;
   logic [CW-1:0] fresh_ff, fresh_in;
   logic [CW-1:0] free_head_ff, free_head_in;
   logic [CW-1:0] bsize_ff [2];
   logic [CW-1:0] bsize_in [2];
   // slice tables, small and held in flops (20 entries, indexed by bucket and slice)
   logic [CW-1:0] ssize_ff [2*NS];
   logic [CW-1:0] ssize_in [2*NS];
   logic [NW-1:0] shead_ff [2*NS];
   logic [NW-1:0] shead_in [2*NS];
   logic [NW-1:0] stail_ff [2*NS];
   logic [NW-1:0] stail_in [2*NS];
   logic [SW-1:0] order_ff [2*NS];
   logic [SW-1:0] order_in [2*NS];

   // transaction context
   logic [1:0]    cmd_ff, cmd_in;
   logic [VW-1:0] val_ff, val_in;
   logic [2:0]    draw_ff, draw_in;
   logic          bk_ff, bk_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [NW-1:0] node_ff, node_in;
   logic          up_ff, up_in;
   logic [VW-1:0] out_val_ff, out_val_in;
   logic [1:0]    out_st_ff, out_st_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // node RAM: {link, value}
   logic                 ram_we;
   logic [NW-1:0]        ram_waddr, ram_raddr;
   logic [NW+VW-1:0]     ram_wdata, ram_rdata;

   rsp_ram #(.Width(NW + VW), .Depth(rsp_pkg::Capacity)) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // bucket-relative helpers
   function automatic logic [4:0] sidx(input logic b, input logic [SW-1:0] p,
                                       input logic [SW-1:0] ord [2*NS]);
      logic [4:0] base;
      base = b ? 5'(NS) : 5'd0;
      return base + 5'(ord[base + 5'(p)]);
   endfunction

   function automatic logic [4:0] oidx(input logic b, input logic [SW-1:0] p);
      return (b ? 5'(NS) : 5'd0) + 5'(p);
   endfunction

   logic [CW-1:0] free_len;
   logic [4:0]    cur_s, prev_s;
   logic [CW-1:0] cur_size, prev_size;

   assign free_len  = fresh_ff - bsize_ff[0] - bsize_ff[1];
   assign cur_s     = sidx(bk_ff, pos_ff, order_ff);
   assign prev_s    = sidx(bk_ff, pos_ff - SW'(1), order_ff);
   assign cur_size  = ssize_ff[cur_s];
   assign prev_size = ssize_ff[prev_s];

   assign req_tready = (state_ff == rsp_pkg::S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, out_st_ff, out_val_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsp_pkg::S_IDLE;
         ring_ff      <= 1'b1;
         pick_sel_ff  <= 1'b0;
         fresh_ff     <= '0;
         free_head_ff <= CW'(rsp_pkg::Capacity);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) bsize_ff[i] <= '0;
         for (int i = 0; i < 2*NS; i++) begin
            ssize_ff[i] <= '0;
            order_ff[i] <= SW'(i % NS);
         end
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) ring_ff <= csr_wr_data;
         pick_sel_ff  <= pick_sel_in;
         fresh_ff     <= fresh_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
         bsize_ff     <= bsize_in;
         ssize_ff     <= ssize_in;
         order_ff     <= order_in;
      end
      shead_ff   <= shead_in;
      stail_ff   <= stail_in;
      cmd_ff     <= cmd_in;
      val_ff     <= val_in;
      draw_ff    <= draw_in;
      bk_ff      <= bk_in;
      pos_ff     <= pos_in;
      node_ff    <= node_in;
      up_ff      <= up_in;
      out_val_ff <= out_val_in;
      out_st_ff  <= out_st_in;
   end

   always_comb begin
      logic [1:0]    c;
      logic          pb, qb, b;
      logic [SW-1:0] p;
      logic [4:0]    s, oa, ob;
      logic [SW-1:0] t;
      logic [NW-1:0] n;
      c = req_tdata[1:0];
      pb = pick_sel_ff;
      qb = ring_ff ? ~pick_sel_ff : pick_sel_ff;
      b = 1'b0; p = '0; s = '0; oa = '0; ob = '0; t = '0; n = '0;

      state_in     = state_ff;
      pick_sel_in  = pick_sel_ff;
      fresh_in     = fresh_ff;
      free_head_in = free_head_ff;
      bsize_in     = bsize_ff;
      ssize_in     = ssize_ff;
      shead_in     = shead_ff;
      stail_in     = stail_ff;
      order_in     = order_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      draw_in      = draw_ff;
      bk_in        = bk_ff;
      pos_in       = pos_ff;
      node_in      = node_ff;
      up_in        = up_ff;
      out_val_in   = out_val_ff;
      out_st_in    = out_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_we       = 1'b0;
      ram_waddr    = node_ff;
      ram_wdata    = {ram_rdata[VW +: NW], val_ff};
      ram_raddr    = free_head_ff[NW-1:0];

      case (state_ff)
         rsp_pkg::S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in     = c;
               val_in     = req_tdata[65:2];
               draw_in    = req_tdata[68:66];
               out_val_in = '0;
               out_st_in  = rsp_pkg::ST_OK;
               if (c == rsp_pkg::CMD_ADD || c == rsp_pkg::CMD_PUT) begin
                  b = (c == rsp_pkg::CMD_ADD) ? pb : qb;
                  bk_in = b;
                  if (free_len == '0 && fresh_ff == CW'(rsp_pkg::Capacity)) begin
                     out_st_in = rsp_pkg::ST_FULL;
                     state_in  = rsp_pkg::S_RESP;
                  end else begin
                     // free head's link is read now, used next cycle
                     node_in  = (free_len != '0) ? free_head_ff[NW-1:0]
                                                 : fresh_ff[NW-1:0];
                     state_in = rsp_pkg::S_PUT_LINK;
                  end
               end else if (c == rsp_pkg::CMD_PICK) begin
                  b = pb;
                  if (ring_ff && bsize_ff[pb] == '0 && bsize_ff[qb] != '0) begin
                     b = qb;
                     pick_sel_in = qb;
                  end
                  bk_in = b;
                  if (bsize_ff[b] == '0) begin
                     out_st_in = rsp_pkg::ST_EMPTY;
                     state_in  = rsp_pkg::S_RESP;
                  end else begin
                     if (ssize_ff[sidx(b, SW'(NS-1), order_ff)] > (bsize_ff[b] >> 1))
                        pos_in = SW'(NS-1);
                     else
                        pos_in = SW'(req_tdata[68:66]) + SW'(NS - rsp_pkg::RandomSlices);
                     state_in = rsp_pkg::S_PICK_SCAN;
                  end
               end else begin
                  state_in = rsp_pkg::S_RESP;
               end
            end
         end

         rsp_pkg::S_PUT_LINK: begin
            n = node_ff;
            if (free_len != '0)
               free_head_in = (free_len > CW'(1)) ? CW'(ram_rdata[VW +: NW])
                                                  : CW'(rsp_pkg::Capacity);
            else
               fresh_in = fresh_ff + CW'(1);
            p = (ssize_ff[sidx(bk_ff, '0, order_ff)] < (bsize_ff[bk_ff] >> 3))
                ? '0 : SW'(draw_ff);
            s = sidx(bk_ff, p, order_ff);
            // node gets its value; link is set later by the next append
            ram_we    = 1'b1;
            ram_waddr = n;
            ram_wdata = {ram_rdata[VW +: NW], val_ff};
            if (ssize_ff[s] == '0) begin
               shead_in[s] = n;
            end else begin
               // tail's link must change: write value then fix link next
               ram_waddr = stail_ff[s];
               ram_raddr = stail_ff[s];
               ram_we    = 1'b0;
            end
            node_in = (ssize_ff[s] == '0) ? n : stail_ff[s];
            up_in   = (ssize_ff[s] != '0);
            // the new node id is carried to the link fix in out_val
            stail_in[s] = n;
            ssize_in[s] = ssize_ff[s] + CW'(1);
            bsize_in[bk_ff] = bsize_ff[bk_ff] + CW'(1);
            pos_in = p;
            if (ssize_ff[s] != '0) begin
               // write new node first
               ram_we    = 1'b1;
               ram_waddr = n;
               ram_wdata = {NW'(0), val_ff};
               out_val_in = VW'(n);
               state_in  = rsp_pkg::S_PICK_DONE;
            end else begin
               state_in = rsp_pkg::S_BUBBLE;
            end
         end

         rsp_pkg::S_PICK_DONE: begin
            if (cmd_ff == rsp_pkg::CMD_PICK) begin
               // pick: head node read data now valid
               out_val_in = ram_rdata[VW-1:0];
               s = cur_s;
               n = shead_ff[s];
               if (cur_size != CW'(1)) shead_in[s] = ram_rdata[VW +: NW];
               ssize_in[s] = cur_size - CW'(1);
               bsize_in[bk_ff] = bsize_ff[bk_ff] - CW'(1);
               ram_we    = 1'b1;
               ram_waddr = n;
               ram_wdata = {(free_len > CW'(0)) ? free_head_ff[NW-1:0]
                                                : ram_rdata[VW +: NW],
                            ram_rdata[VW-1:0]};
               free_head_in = CW'(n);
               up_in    = 1'b0;
               state_in = rsp_pkg::S_BUBBLE;
            end else begin
               // add/put: rewrite old tail link, keeping its value
               ram_we    = 1'b1;
               ram_waddr = node_ff;
               ram_wdata = {out_val_ff[NW-1:0], ram_rdata[VW-1:0]};
               out_val_in = '0;
               state_in = rsp_pkg::S_BUBBLE;
            end
         end

         rsp_pkg::S_PICK_SCAN: begin
            if (pos_ff >= SW'(NS)) begin
               out_st_in = rsp_pkg::ST_EMPTY;
               state_in  = rsp_pkg::S_RESP;
            end else if (cur_size != '0) begin
               ram_raddr = shead_ff[cur_s];
               state_in  = rsp_pkg::S_PICK_DONE;
            end else begin
               pos_in = pos_ff + SW'(1);
            end
         end

         rsp_pkg::S_BUBBLE: begin
            // one compare-and-swap per cycle
            oa = oidx(bk_ff, pos_ff);
            if (up_ff || cmd_ff != rsp_pkg::CMD_PICK) begin
               ob = oidx(bk_ff, pos_ff + SW'(1));
               if (pos_ff + SW'(1) < SW'(rsp_pkg::RandomSlices) &&
                   ssize_ff[sidx(bk_ff, pos_ff + SW'(1), order_ff)] < cur_size) begin
                  t = order_ff[oa];
                  order_in[oa] = order_ff[ob];
                  order_in[ob] = t;
                  pos_in = pos_ff + SW'(1);
               end else begin
                  state_in = rsp_pkg::S_RESP;
               end
            end else begin
               ob = oidx(bk_ff, pos_ff - SW'(1));
               if (pos_ff != '0 && prev_size > cur_size) begin
                  t = order_ff[oa];
                  order_in[oa] = order_ff[ob];
                  order_in[ob] = t;
                  pos_in = pos_ff - SW'(1);
               end else begin
                  state_in = rsp_pkg::S_RESP;
               end
            end
         end

         rsp_pkg::S_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = rsp_pkg::S_IDLE;
            end
         end

         default: state_in = rsp_pkg::S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== bench/randomized_slice_pool_unit_tb.sv =====
`timescale 1ns / 1ps
// Pool predictor: a straight port of the block's behavior on two buckets of
// FIFO slices, with its own node store, free list and slice order.
class pool_scoreboard;
   bit [63:0]                node_val [rsp_pkg::Capacity];
   bit [rsp_pkg::NodeW-1:0]  node_nxt [rsp_pkg::Capacity];
   int unsigned     free_top;
   int unsigned     fresh;
   int unsigned     head [2*rsp_pkg::Slices];
   int unsigned     tail [2*rsp_pkg::Slices];
   int unsigned     fill [2*rsp_pkg::Slices];
   int unsigned     order [2*rsp_pkg::Slices];
   int unsigned     bsize [2];
   bit              pick_sel;
   bit              ring;
   bit [65:0]       pending [$];
   int              mismatches;

   function new();
      ring = 1'b1;
      free_top = rsp_pkg::Capacity;
      fresh = 0;
      pick_sel = 0;
      bsize[0] = 0;
      bsize[1] = 0;
      mismatches = 0;
      for (int i = 0; i < 2*rsp_pkg::Slices; i++) begin
         fill[i] = 0;
         order[i] = i % rsp_pkg::Slices;
         head[i] = 0;
         tail[i] = 0;
      end
   endfunction

   function int unsigned free_len();
      return fresh - bsize[0] - bsize[1];
   endfunction

   function int unsigned fill_at(int unsigned b, int unsigned p);
      return fill[b*rsp_pkg::Slices + order[b*rsp_pkg::Slices + p]];
   endfunction

   function void swap_pos(int unsigned b, int unsigned i, int unsigned j);
      int unsigned t;
      t = order[b*rsp_pkg::Slices + i];
      order[b*rsp_pkg::Slices + i] = order[b*rsp_pkg::Slices + j];
      order[b*rsp_pkg::Slices + j] = t;
   endfunction

   function bit store(int unsigned b, bit [63:0] v, int unsigned draw);
      int unsigned n, p, s;
      if (free_len() > 0) begin
         n = free_top;
         free_top = (free_len() > 1) ? node_nxt[n] : rsp_pkg::Capacity;
      end else if (fresh < rsp_pkg::Capacity) begin
         n = fresh;
         fresh++;
      end else begin
         return 0;
      end
      node_val[n] = v;
      p = (fill_at(b, 0) < (bsize[b] >> 3)) ? 0 : draw;
      s = b*rsp_pkg::Slices + order[b*rsp_pkg::Slices + p];
      if (fill[s] == 0) head[s] = n;
      else node_nxt[tail[s]] = n;
      tail[s] = n;
      fill[s]++;
      bsize[b]++;
      for (int i = p + 1; i < rsp_pkg::RandomSlices; i++) begin
         if (fill_at(b, i) < fill_at(b, i-1)) swap_pos(b, i-1, i);
         else break;
      end
      return 1;
   endfunction

   function bit take(int unsigned b, int unsigned draw, output bit [63:0] v);
      int unsigned p, s, n;
      v = '0;
      if (bsize[b] == 0) return 0;
      if (fill_at(b, rsp_pkg::Slices-1) > (bsize[b] >> 1)) p = rsp_pkg::Slices - 1;
      else p = draw + (rsp_pkg::Slices - rsp_pkg::RandomSlices);
      while (p < rsp_pkg::Slices && fill_at(b, p) == 0) p++;
      if (p >= rsp_pkg::Slices) return 0;
      s = b*rsp_pkg::Slices + order[b*rsp_pkg::Slices + p];
      n = head[s];
      v = node_val[n];
      fill[s]--;
      if (fill[s] != 0) head[s] = node_nxt[n];
      bsize[b]--;
      if (free_len() > 1) node_nxt[n] = free_top;
      free_top = n;
      for (int i = p; i > 0; i--) begin
         if (fill_at(b, i-1) > fill_at(b, i)) swap_pos(b, i-1, i);
         else break;
      end
      return 1;
   endfunction

   // notes an accepted request transaction and queues its expected response
   function void note_request(bit [1:0] cmd, bit [63:0] v, bit [2:0] rnd);
      int unsigned draw, pb, qb;
      bit [63:0] got;
      bit [1:0] st;
      draw = rnd % rsp_pkg::RandomSlices;
      pb = pick_sel;
      qb = ring ? (pb ^ 1) : pb;
      got = '0;
      st = rsp_pkg::ST_OK;
      if (cmd == rsp_pkg::CMD_ADD) begin
         if (!store(pb, v, draw)) st = rsp_pkg::ST_FULL;
      end else if (cmd == rsp_pkg::CMD_PUT) begin
         if (!store(qb, v, draw)) st = rsp_pkg::ST_FULL;
      end else if (cmd == rsp_pkg::CMD_PICK) begin
         if (ring && bsize[pb] == 0 && bsize[qb] != 0) begin
            pick_sel = qb;
            pb = qb;
         end
         if (!take(pb, draw, got)) begin
            got = '0;
            st = rsp_pkg::ST_EMPTY;
         end
      end
      pending.push_back({st, got});
   endfunction

   function void check_response(bit [71:0] d);
      bit [65:0] e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %h", d);
         return;
      end
      e = pending.pop_front();
      if (d[63:0] !== e[63:0] || d[65:64] !== e[65:64] || d[71:66] !== '0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                     e[63:0], d[63:0], e[65:64], d[65:64]);
      end
   endfunction
endclass

module randomized_slice_pool_unit_tb;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        csr_wr_en = 0;
   logic        csr_wr_data = 0;

   pool_scoreboard board;
   bit sink_hold;    // long receiver hold-off, driven by its own process

   randomized_slice_pool_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // offers one request transaction, then waits for acceptance;
   // valid stays up so back-to-back requests need no second drive
   task automatic send(bit [1:0] cmd, bit [63:0] v, bit [2:0] rnd, bit no_gap = 0);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, rnd, v, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, v, rnd);
   endtask

   task automatic idle_req();
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      idle_req();
      while (board.pending.size() != 0) @(posedge clock);
      // an unknown command yields a response too, so only pipeline slack remains
      repeat (30) @(posedge clock);
   endtask

   task automatic write_ring(bit m);
      idle_req();
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      board.ring = m;
      csr_wr_en <= 1'b0;
   endtask

   function automatic bit [63:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7FFF_FFFF_FFFF_FFFF;
         2: return '1;
         3: return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // random phase: add/put and pick mixed per request, weighted by fill_bias, plus noise
   task automatic random_phase(int n, int fill_bias);
      bit [1:0] cmd;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 2) cmd = CMD_UNKNOWN;
         else if (r < fill_bias)
            cmd = ($urandom_range(0, 1) != 0) ? rsp_pkg::CMD_ADD : rsp_pkg::CMD_PUT;
         else cmd = rsp_pkg::CMD_PICK;
         send(cmd, rand_value(), 3'($urandom_range(0, 7)));
      end
   endtask

   // response side: random stalls, plus the long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         if (sink_hold) rsp_tready <= 1'b0;
         else if ($urandom_range(0, 3) == 0) rsp_tready <= ($urandom_range(0, 9) == 0);
         else rsp_tready <= 1'b1;
      end
   end

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty picks, extremes, every command, draw extremes
      send(rsp_pkg::CMD_PICK, '0, 3'd0);
      send(rsp_pkg::CMD_ADD, 64'h8000_0000_0000_0000, 3'd0);
      send(rsp_pkg::CMD_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 3'd7);
      send(rsp_pkg::CMD_PUT, '1, 3'd7);
      send(rsp_pkg::CMD_PUT, '0, 3'd5);
      send(CMD_UNKNOWN, 64'h1234, 3'd2);
      for (int i = 0; i < 6; i++) send(rsp_pkg::CMD_PICK, '0, 3'(i + 2));
      send(rsp_pkg::CMD_PICK, '1, 3'd7);
      drain();

      // single bucket mode
      write_ring(1'b0);
      for (int i = 0; i < 8; i++) send(rsp_pkg::CMD_PUT, {$urandom, $urandom}, 3'(i));
      for (int i = 0; i < 9; i++) send(rsp_pkg::CMD_PICK, '0, 3'(7 - i));
      drain();
      write_ring(1'b1);

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            sink_hold = 1;
            repeat (400) @(posedge clock);
            sink_hold = 0;
         end
         begin
            for (int i = 0; i < 20; i++)
               send(rsp_pkg::CMD_ADD, {$urandom, $urandom}, 3'(i), 1);
            idle_req();
         end
      join
      drain();

      random_phase(200, 60);
      drain();

      // fill past capacity to hit full status, then pick 40 back in single bucket mode
      for (int i = 0; i < 1040; i++)
         send(($urandom_range(0, 1) != 0) ? rsp_pkg::CMD_ADD : rsp_pkg::CMD_PUT,
              {$urandom, $urandom}, 3'($urandom_range(0, 7)), $urandom_range(0, 9) != 0);
      drain();
      write_ring(1'b0);
      for (int i = 0; i < 40; i++) send(rsp_pkg::CMD_PICK, '0, 3'($urandom_range(0, 7)));
      drain();
      write_ring(1'b1);
      random_phase(150, 30);
      drain();
      write_ring(1'b0);
      random_phase(120, 50);
      drain();
      write_ring(1'b1);
      random_phase(150, 45);
      drain();

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_ram.sv
hw/rtl/randomized_slice_pool_unit.sv
bench/randomized_slice_pool_unit_tb.sv
